// ===== src/calorimeter_cluster_correction_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef CALORIMETER_CLUSTER_CORRECTION_UNIT_MACROS_SVH
`define CALORIMETER_CLUSTER_CORRECTION_UNIT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CCC_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define CCC_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

// ===== src/ccc_pkg.sv =====
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared constants, types and arithmetic helpers of the cluster correction.
// ----------------------------------------------------------------------------
package ccc_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_BINS_DEF  = 16;
  localparam int COEF_SLOTS    = 3;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_STEP_X = 2'd0,
    REG_STEP_Y = 2'd1,
    REG_DEPTH  = 2'd2,
    REG_FRONT  = 2'd3
  } reg_idx_t;

  // Input item kinds.
  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_CORRECT = 1'b1;

  // Coefficient slots.
  localparam logic [1:0] SLOT_A = 2'd0;
  localparam logic [1:0] SLOT_B = 2'd1;
  localparam logic [1:0] SLOT_C = 2'd2;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // Upper bin edges in quarters of a crystal step.
  function automatic logic [5:0] bin_top_q(input logic [3:0] i);
    case (i)
      4'd0: bin_top_q = 6'd14;   4'd1: bin_top_q = 6'd15;
      4'd2: bin_top_q = 6'd16;   4'd3: bin_top_q = 6'd18;
      4'd4: bin_top_q = 6'd22;   4'd5: bin_top_q = 6'd26;
      4'd6: bin_top_q = 6'd30;   4'd7: bin_top_q = 6'd34;
      4'd8: bin_top_q = 6'd38;   4'd9: bin_top_q = 6'd40;
      4'd10: bin_top_q = 6'd41;  4'd11: bin_top_q = 6'd42;
      4'd12: bin_top_q = 6'd43;  4'd13: bin_top_q = 6'd44;
      4'd14: bin_top_q = 6'd45;  default: bin_top_q = 6'd46;
    endcase
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'(S32_MAX)) sat32 = 32'h7fff_ffff;
    else if (v < 66'(S32_MIN)) sat32 = 32'h8000_0000;
    else sat32 = v[31:0];
  endfunction

  // Saturating unsigned 64-bit add.
  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    add_sat = s[64] ? '1 : s[63:0];
  endfunction

  // Magnitude of a 32-bit signed value.
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction
endpackage

// ===== src/calorimeter_cluster_correction_unit.sv =====
// ----------------------------------------------------------------------------
// calorimeter_cluster_correction_unit
// Corrects a cluster's energy and position with binned coefficients.
//
// Input channel (in_valid/in_stall): action 0 writes one coefficient into the
// table and gives no result; action 1 corrects one cluster and gives one beat
// on the output channel (out_valid/out_stall).
// Configuration channel (cfg_valid/cfg_ready) writes the four registers; it
// is always ready and must be written only while the block is idle; the block
// does not enforce this. Throughput is one item per cycle while the output is
// not stalled. Both paths start after the step-ratio divide. At FRAC_BITS 16
// the position path (two square roots and two divides, stage registers and the
// output register) is the longer; the energy path (three chained divides)
// is shorter and is delayed to match.
// A coefficient write takes effect in pipeline order at the table read stage,
// so clusters accepted before it still see the old value.
// The whole pipeline advances together; when the output stalls, the last
// stage holds and the input stalls too. A one-beat output register lets a
// finished result wait while nothing is lost.
// Reset clears the registers to their defaults and empties the pipeline; the
// coefficient table holds nothing until written.
// ----------------------------------------------------------------------------
module calorimeter_cluster_correction_unit
  import ccc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [3:0]         coef_bin,
  input  logic [1:0]         coef_slot,
  input  logic signed [31:0] coef_value,
  input  logic [30:0]        energy_in,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] energy_out,
  output logic signed [31:0] corr_x,
  output logic signed [31:0] corr_y,
  output logic               status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam int DQ = 34 + FRAC_BITS;       // divider stage count
  localparam int SQ = 32;                   // square-root stage count

  logic en;
  logic [30:0] step_x, step_y;
  logic signed [31:0] shower_depth, front_distance;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_x <= 31'd88211;
      step_y <= 31'd89129;
      shower_depth <= '0;
      front_distance <= 32'sd3604480;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STEP_X: step_x <= cfg_data[30:0];
        REG_STEP_Y: step_y <= cfg_data[30:0];
        REG_DEPTH:  shower_depth <= cfg_data;
        REG_FRONT:  front_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register: the pipe moves unless a held result is stalled.
  logic pv;
  logic signed [31:0] p_e, p_x, p_y;
  logic p_st;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  logic acc;
  assign acc = in_valid && !in_stall;

  // Write requests travel with the pipe so they reach the table in order.
  logic wdl [DQ+2];
  assign wdl[0] = acc && action == ACT_WRITE;
  for (genvar i = 0; i < DQ + 1; i++) begin : g_wd
    always_ff @(posedge clk) begin
      if (rst) wdl[i+1] <= 1'b0;
      else if (en) wdl[i+1] <= wdl[i];
    end
  end

  // ---------------- Step ratios ----------------
  localparam int TAG0 = 31 + 32 + 32 + 32 + 32;
  localparam int TW = 4 + 2 + 32;
  logic [TAG0-1:0] t0_in, t0_out;
  assign t0_in = {energy_in, pos_x, pos_y, shower_depth, front_distance};
  logic signed [31:0] rxq, ryq;
  logic rx_dz, ry_dz;
  logic [TW-1:0] tw_out;
  ccc_div #(.FRAC_BITS(FRAC_BITS), .TAGW(TAG0)) u_rx (
    .clk, .en, .num(34'(signed'({1'b0, mag32(pos_x)}))),
    .den(64'(signed'({1'b0, step_x}))), .tag_in(t0_in),
    .quo(rxq), .dz(rx_dz), .tag_out(t0_out));
  ccc_div #(.FRAC_BITS(FRAC_BITS), .TAGW(TW)) u_ry (
    .clk, .en, .num(34'(signed'({1'b0, mag32(pos_y)}))),
    .den(64'(signed'({1'b0, step_y}))), .tag_in({coef_bin, coef_slot, coef_value}),
    .quo(ryq), .dz(ry_dz), .tag_out(tw_out));

  logic [30:0] e1;
  logic signed [31:0] x1, y1, dp1, z1;
  assign {e1, x1, y1, dp1, z1} = t0_out;
  logic [3:0] wbin1; logic [1:0] wslot1; logic signed [31:0] wval1;
  assign {wbin1, wslot1, wval1} = tw_out;

  // Cap the ratios and square them; register before binning.
  localparam logic signed [31:0] CAP = 32'(16 << FRAC_BITS);
  logic [63:0] r2;
  logic st2;
  logic [30:0] e2;
  logic [3:0] wbin2; logic [1:0] wslot2; logic signed [31:0] wval2;
  always_ff @(posedge clk) begin
    if (en) begin
      r2  <= 64'(64'(rxq > CAP ? CAP : rxq) * 64'(rxq > CAP ? CAP : rxq))
           + 64'(64'(ryq > CAP ? CAP : ryq) * 64'(ryq > CAP ? CAP : ryq));
      st2 <= rx_dz | ry_dz;
      e2 <= e1;
      wbin2 <= wbin1; wslot2 <= wslot1; wval2 <= wval1;
    end
  end

  // Bin search over all sixteen bin tops and coefficient address.
  logic [3:0] bin;
  always_comb begin
    bin = 4'd15;
    for (int i = 15; i >= 0; i--) begin
      if (r2 <= (64'(bin_top_q(4'(i))) * 64'(bin_top_q(4'(i)))) << (2 * FRAC_BITS - 4))
        bin = 4'(i);
    end
  end

  // Coefficient memory, one word per bin holding a, b and c.
  logic [95:0] coef_mem [16];
  always_ff @(posedge clk) begin
    if (en && wdl[DQ+1]) begin
      case (wslot2)
        SLOT_A: coef_mem[wbin2][31:0]  <= wval2;
        SLOT_B: coef_mem[wbin2][63:32] <= wval2;
        SLOT_C: coef_mem[wbin2][95:64] <= wval2;
        default: ;
      endcase
    end
  end

  // Memory read: the bin's word, registered.
  logic [95:0] crow;
  logic signed [31:0] ca, cb, cc;
  logic st3;
  logic [30:0] e3;
  always_ff @(posedge clk) begin
    if (en) begin
      crow <= coef_mem[bin];
      st3 <= st2;
      e3 <= e2;
    end
  end
  assign ca = crow[31:0];
  assign cb = crow[63:32];
  assign cc = crow[95:64];

  // ---------------- Energy: q = b/a, d = e-c ----------------
  localparam int TE = 1 + 31 + 32 + 32;
  logic signed [31:0] qba; logic dz_q;
  logic [TE-1:0] te_out;
  ccc_div #(.FRAC_BITS(FRAC_BITS), .TAGW(TE)) u_qba (
    .clk, .en, .num(34'(cb)), .den(64'(ca)),
    .tag_in({st3, e3, ca, sat32(66'(signed'({1'b0, e3})) - 66'(cc))}),
    .quo(qba), .dz(dz_q), .tag_out(te_out));
  logic st4; logic [30:0] e4; logic signed [31:0] a4, d4;
  assign {st4, e4, a4, d4} = te_out;

  // num = a*d, den = d+q; registered product.
  logic signed [63:0] pr5;
  logic signed [31:0] den5;
  logic st5; logic [30:0] e5;
  always_ff @(posedge clk) begin
    if (en) begin
      pr5 <= 64'(a4) * 64'(d4);
      den5 <= sat32(66'(d4) + 66'(qba));
      st5 <= st4 | dz_q;
      e5 <= e4;
    end
  end
  logic signed [31:0] num5;
  assign num5 = sat32(66'(pr5 >>> FRAC_BITS));

  logic signed [31:0] corr; logic dz_c;
  logic [31:0] tc_out;
  ccc_div #(.FRAC_BITS(FRAC_BITS), .TAGW(32)) u_corr (
    .clk, .en, .num(34'(num5)), .den(64'(den5)), .tag_in({st5, e5}),
    .quo(corr), .dz(dz_c), .tag_out(tc_out));

  logic signed [31:0] eo; logic dz_e; logic [0:0] te2;
  ccc_div #(.FRAC_BITS(FRAC_BITS), .TAGW(1)) u_eo (
    .clk, .en, .num(34'(signed'({1'b0, tc_out[30:0]}))), .den(64'(corr)),
    .tag_in(tc_out[31] | dz_c), .quo(eo), .dz(dz_e), .tag_out(te2));
  logic st_e;
  assign st_e = te2[0] | dz_e;
  localparam int ELAT = 2 * DQ;   // divider stages from u_corr input to eo

  // ---------------- Position ----------------
  // Squares and zd, registered (starts at stage 1 outputs).
  logic [63:0] sx6, sy6;
  logic signed [31:0] zd6, x6, y6, dp6, z6;
  always_ff @(posedge clk) begin
    if (en) begin
      sx6 <= 64'(mag32(x1)) * 64'(mag32(x1));
      sy6 <= 64'(mag32(y1)) * 64'(mag32(y1));
      zd6 <= sat32(66'(z1) + 66'(dp1));
      x6 <= x1; y6 <= y1; dp6 <= dp1; z6 <= z1;
    end
  end
  logic [63:0] szd7, rr7; logic signed [63:0] pdz7;
  logic signed [31:0] x7, y7, dp7, z7;
  always_ff @(posedge clk) begin
    if (en) begin
      szd7 <= 64'(mag32(zd6)) * 64'(mag32(zd6));
      pdz7 <= 64'(dp6) * 64'(zd6);
      rr7 <= add_sat(sx6, sy6);
      x7 <= x6; y7 <= y6; dp7 <= dp6; z7 <= z6;
    end
  end

  // h1 = sqrt(rr + zd^2); the tag carries fmul(deep, zd) and the rest.
  localparam int TH = 32 * 5 + 64;
  logic [31:0] h1; logic [TH-1:0] th_out;
  ccc_sqrt #(.TAGW(TH)) u_h1 (
    .clk, .en, .val(add_sat(rr7, szd7)),
    .tag_in({sat32(66'(pdz7 >>> FRAC_BITS)), x7, y7, dp7, z7, rr7}),
    .root(h1), .tag_out(th_out));
  logic signed [31:0] fdz8, x8, y8, dp8, z8; logic [63:0] rr8;
  assign {fdz8, x8, y8, dp8, z8, rr8} = th_out;

  localparam int TT = 32 * 4 + 64;
  logic signed [31:0] tq; logic dz_t; logic [TT-1:0] tt_out;
  ccc_div #(.FRAC_BITS(FRAC_BITS), .TAGW(TT)) u_t (
    .clk, .en, .num(34'(fdz8)), .den(64'({32'd0, h1})),
    .tag_in({x8, y8, dp8, z8, rr8}), .quo(tq), .dz(dz_t), .tag_out(tt_out));
  logic signed [31:0] x9, y9, dp9, z9; logic [63:0] rr9;
  assign {x9, y9, dp9, z9, rr9} = tt_out;

  // zz and its square, with deep*x, deep*y.
  logic signed [31:0] zz10, x10, y10; logic [63:0] rr10; logic st10;
  logic signed [63:0] px10, py10;
  always_ff @(posedge clk) begin
    if (en) begin
      zz10 <= sat32(66'(z9) + 66'(tq));
      px10 <= 64'(dp9) * 64'(x9);
      py10 <= 64'(dp9) * 64'(y9);
      rr10 <= rr9; x10 <= x9; y10 <= y9; st10 <= dz_t;
    end
  end
  logic [63:0] szz11, rr11; logic signed [31:0] fx11, fy11, x11, y11; logic st11;
  always_ff @(posedge clk) begin
    if (en) begin
      szz11 <= 64'(mag32(zz10)) * 64'(mag32(zz10));
      fx11 <= sat32(66'(px10 >>> FRAC_BITS));
      fy11 <= sat32(66'(py10 >>> FRAC_BITS));
      rr11 <= rr10; x11 <= x10; y11 <= y10; st11 <= st10;
    end
  end
  localparam int TH2 = 32 * 4 + 1;
  logic [31:0] h2; logic [TH2-1:0] th2_out;
  ccc_sqrt #(.TAGW(TH2)) u_h2 (
    .clk, .en, .val(add_sat(rr11, szz11)), .tag_in({fx11, fy11, x11, y11, st11}),
    .root(h2), .tag_out(th2_out));
  logic signed [31:0] fx12, fy12, x12, y12; logic st12;
  assign {fx12, fy12, x12, y12, st12} = th2_out;

  logic signed [31:0] qx, qy; logic dz_x, dz_y;
  logic [32:0] tx_out; logic [31:0] ty_out;
  ccc_div #(.FRAC_BITS(FRAC_BITS), .TAGW(33)) u_cx (
    .clk, .en, .num(34'(fx12)), .den(64'({32'd0, h2})), .tag_in({x12, st12}),
    .quo(qx), .dz(dz_x), .tag_out(tx_out));
  ccc_div #(.FRAC_BITS(FRAC_BITS), .TAGW(32)) u_cy (
    .clk, .en, .num(34'(fy12)), .den(64'({32'd0, h2})), .tag_in(y12),
    .quo(qy), .dz(dz_y), .tag_out(ty_out));

  logic signed [31:0] px_o, py_o; logic pst_o;
  assign px_o = sat32(66'(signed'(tx_out[32:1])) - 66'(qx));
  assign py_o = sat32(66'(signed'(ty_out)) - 66'(qy));
  assign pst_o = tx_out[0] | dz_x | dz_y;

  // Position path from stage 1: sx6, szd7, u_h1, u_t, zz10, szz11, u_h2, u_cx.
  // Energy path from stage 1: r2, crow, u_qba, pr5, u_corr, u_eo.
  localparam int PLAT = 2 + SQ + DQ + 2 + SQ + DQ;
  localparam int EL   = 2 + DQ + 1 + ELAT;
  localparam int LAT  = (PLAT > EL) ? PLAT : EL;

  // Align both paths into the later one with delay lines.
  localparam int PD = LAT - PLAT;
  localparam int ED = LAT - EL;
  logic [64:0] pdl [PD+1];
  logic [32:0] edl [ED+1];
  logic        vdl [DQ+LAT+1];
  assign pdl[0] = {px_o, py_o, pst_o};
  assign edl[0] = {eo, st_e};
  assign vdl[0] = acc && action == ACT_CORRECT;
  for (genvar i = 0; i < PD; i++) begin : g_pd
    always_ff @(posedge clk) if (en) pdl[i+1] <= pdl[i];
  end
  for (genvar i = 0; i < ED; i++) begin : g_ed
    always_ff @(posedge clk) if (en) edl[i+1] <= edl[i];
  end
  // Beat valid bits from the accepting edge to the output register.
  for (genvar i = 0; i < DQ + LAT; i++) begin : g_vd
    always_ff @(posedge clk) begin
      if (rst) vdl[i+1] <= 1'b0;
      else if (en) vdl[i+1] <= vdl[i];
    end
  end

  // Output register.
  assign pv = vdl[DQ+LAT];
  assign {p_x, p_y} = pdl[PD][64:1];
  assign p_e = edl[ED][32:1];
  assign p_st = pdl[PD][0] | edl[ED][0];
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= pv;
    if (en) begin
      energy_out <= p_e; corr_x <= p_x; corr_y <= p_y; status <= p_st;
    end
  end
endmodule

// ===== src/ccc_div.sv =====
// ----------------------------------------------------------------------------
// ccc_div
// Pipelined restoring divider, one quotient bit per stage, signed fixed point.
// Quotient is (n << frac) / d truncated toward zero, saturated to 32 bits.
// A zero divisor raises the flag and saturates by n's sign (zero for zero n).
// ----------------------------------------------------------------------------
module ccc_div
  import ccc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int TAGW = 1
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [33:0]  num,
  input  logic signed [63:0]  den,
  input  logic [TAGW-1:0]     tag_in,
  output logic signed [31:0]  quo,
  output logic                dz,
  output logic [TAGW-1:0]     tag_out
);
  // Dividend magnitude width; quotient bits needed before saturation is known.
  localparam int NW = 34 + FRAC_BITS;
  localparam int QW = NW;

  logic [NW-1:0] n_mag [QW+1];
  logic [63:0]   d_mag [QW+1];
  logic [64:0]   rem   [QW+1];
  logic [QW-1:0] q     [QW+1];
  logic          neg   [QW+1];
  logic          zd    [QW+1];
  logic          nz    [QW+1];
  logic          npos  [QW+1];
  logic [TAGW-1:0] tg  [QW+1];

  // Stage zero takes the operands apart into sign and magnitude.
  always_comb begin
    logic [33:0] na;
    na = num[33] ? 34'(-num) : 34'(num);
    n_mag[0] = {na, {FRAC_BITS{1'b0}}};
    d_mag[0] = den[63] ? 64'(-den) : 64'(den);
    rem[0]   = '0;
    q[0]     = '0;
    neg[0]   = num[33] ^ den[63];
    zd[0]    = (den == '0);
    nz[0]    = (num != '0);
    npos[0]  = ~num[33] & (num != '0);
    tg[0]    = tag_in;
  end

  // One quotient bit per registered stage.
  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [64:0] tr;
    assign tr = {rem[s][63:0], n_mag[s][NW-1-s]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (tr >= {1'b0, d_mag[s]}) begin
          rem[s+1] <= tr - {1'b0, d_mag[s]};
          q[s+1]   <= {q[s][QW-2:0], 1'b1};
        end else begin
          rem[s+1] <= tr;
          q[s+1]   <= {q[s][QW-2:0], 1'b0};
        end
        n_mag[s+1] <= n_mag[s];
        d_mag[s+1] <= d_mag[s];
        neg[s+1]   <= neg[s];
        zd[s+1]    <= zd[s];
        nz[s+1]    <= nz[s];
        npos[s+1]  <= npos[s];
        tg[s+1]    <= tg[s];
      end
    end
  end

  // Sign, saturation and divide-by-zero handling.
  always_comb begin
    logic signed [65:0] sq;
    sq = neg[QW] ? -$signed({2'b00, 64'(q[QW])}) : $signed({2'b00, 64'(q[QW])});
    if (zd[QW]) begin
      quo = !nz[QW] ? 32'sd0 : (npos[QW] ? 32'h7fff_ffff : 32'h8000_0000);
    end else begin
      quo = sat32(sq);
    end
    dz      = zd[QW];
    tag_out = tg[QW];
  end
endmodule

// ===== src/ccc_sqrt.sv =====
// ----------------------------------------------------------------------------
// ccc_sqrt
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module ccc_sqrt #(
  parameter int TAGW = 1
) (
  input  logic            clk,
  input  logic            en,
  input  logic [63:0]     val,
  input  logic [TAGW-1:0] tag_in,
  output logic [31:0]     root,
  output logic [TAGW-1:0] tag_out
);
  logic [63:0] v   [33];
  logic [65:0] rem [33];
  logic [31:0] r   [33];
  logic [TAGW-1:0] tg [33];

  assign v[0]   = val;
  assign rem[0] = '0;
  assign r[0]   = '0;
  assign tg[0]  = tag_in;

  // Digit-by-digit root, two radicand bits per stage.
  for (genvar s = 0; s < 32; s++) begin : g_stage
    logic [65:0] tr, trial;
    assign tr    = {rem[s][63:0], v[s][63-2*s -: 2]};
    assign trial = {32'd0, r[s], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        if (tr >= trial) begin
          rem[s+1] <= tr - trial;
          r[s+1]   <= {r[s][30:0], 1'b1};
        end else begin
          rem[s+1] <= tr;
          r[s+1]   <= {r[s][30:0], 1'b0};
        end
        v[s+1]  <= v[s];
        tg[s+1] <= tg[s];
      end
    end
  end

  assign root    = r[32];
  assign tag_out = tg[32];
endmodule

// ===== src/ccc_checker.sv =====
// ----------------------------------------------------------------------------
// ccc_checker
// Port-level checks on the cluster correction unit.
// ----------------------------------------------------------------------------
`include "calorimeter_cluster_correction_unit_macros.svh"
module ccc_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic signed [31:0] energy_out,
  input logic cfg_ready
);
  // A held result stalls the input side.
  `CCC_ASSERT_IMP(a_stall, clk, rst, out_valid && out_stall, in_stall, "input not stalled")
  // A stalled beat stays valid and keeps its energy value.
  `CCC_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(energy_out), "held beat changed")
  // Configuration is always taken.
  `CCC_ASSERT_IMP(a_cfg, clk, rst, 1'b1, cfg_ready, "cfg not ready")
endmodule

bind calorimeter_cluster_correction_unit ccc_checker u_chk (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .energy_out, .cfg_ready);
